[rtl/spe_pkg.sv]
// Shared types and constants for the sinusoidal position encoding adder.
// No dependencies; spe_freq, spe_trig and the top level import this package.
`timescale 1ns / 1ps
package spe_pkg;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_POS = 2'd1,
    ST_IDX = 2'd2
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [11:0] pos;
    logic        want_cos;
    status_t     status;
  } tag_t;

  localparam logic CFG_MAX_POSITIONS = 1'b0;
  localparam logic CFG_MODEL_WIDTH   = 1'b1;

  localparam logic [12:0] MAX_POSITIONS = 13'd4096;
  localparam logic [10:0] MAX_WIDTH     = 11'd1024;

  localparam int EXP_FRAC = 12;
  localparam int DIV_BITS = 26;

  localparam logic [27:0] LOG2_TEN_K_Q24 = 28'd222930821;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [29:0] GAIN_Q30       = 30'd652032874;
  localparam logic [30:0] ONE_Q30        = 31'd1073741824;

  function automatic logic [29:0] pow_q30(input int b);
    logic [29:0] r;
    case (b)
      0:  r = 30'd759250125;
      1:  r = 30'd902905651;
      2:  r = 30'd984625594;
      3:  r = 30'd1028218693;
      4:  r = 30'd1050733751;
      5:  r = 30'd1062175491;
      6:  r = 30'd1067942999;
      7:  r = 30'd1070838486;
      8:  r = 30'd1072289173;
      9:  r = 30'd1073015252;
      10: r = 30'd1073378477;
      11: r = 30'd1073560135;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051D;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[rtl/spe_freq.sv]
// Frequency pipeline: exponent by long division, 2^-x by table products,
// then turns per position. Depends on spe_pkg.
`timescale 1ns / 1ps
module spe_freq #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  spe_pkg::tag_t         in_tag,
  input  logic [VALUE_BITS-1:0] in_val,
  input  logic [9:0]            in_idx,
  input  logic [10:0]           width,
  output spe_pkg::tag_t         out_tag,
  output logic [VALUE_BITS-1:0] out_val,
  output logic [31:0]           out_t
);
  import spe_pkg::*;

  localparam int S_DIV  = 1;
  localparam int S_EXP  = S_DIV + DIV_BITS;
  localparam int S_SHF  = S_EXP + EXP_FRAC;
  localparam int S_MUL  = S_SHF + 1;
  localparam int NSTG   = S_MUL + 1;

  tag_t                  tag [0:NSTG-1];
  logic [VALUE_BITS-1:0] val [0:NSTG-1];

  logic [22:0] rem [0:DIV_BITS];
  logic [25:0] lo  [0:DIV_BITS];
  logic [25:0] quo [0:DIV_BITS];
  logic [30:0] em  [0:EXP_FRAC];
  logic [25:0] ex  [0:EXP_FRAC];
  logic [30:0] freq;
  logic [31:0] tpp;

  logic [37:0] num;
  logic [23:0] den;

  assign num = 38'({in_idx[9:1], 1'b0}) * 38'(LOG2_TEN_K_Q24);
  assign den = {1'b0, width, 12'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0] <= '0;
    end else if (en) begin
      tag[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val[0] <= in_val;
      rem[0] <= {11'd0, num[37:26]};
      lo[0]  <= num[25:0];
      quo[0] <= '0;
    end
  end

  genvar s;
  generate
    for (s = 1; s < NSTG; s++) begin : g_tag
      always_ff @(posedge clk) begin
        if (rst) begin
          tag[s] <= '0;
        end else if (en) begin
          tag[s] <= tag[s-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          val[s] <= val[s-1];
        end
      end
    end

    for (s = 0; s < DIV_BITS; s++) begin : g_div
      logic [23:0] cand;
      logic        take;
      logic [23:0] diff;
      assign cand = {rem[s], lo[s][25]};
      assign take = (cand >= den);
      assign diff = cand - den;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= take ? diff[22:0] : cand[22:0];
          lo[s+1]  <= {lo[s][24:0], 1'b0};
          quo[s+1] <= {quo[s][24:0], take};
        end
      end
    end

    assign em[0] = ONE_Q30;
    assign ex[0] = quo[DIV_BITS];

    for (s = 0; s < EXP_FRAC; s++) begin : g_exp
      logic [60:0] prod;
      assign prod = 61'(em[s]) * 61'(pow_q30(s));
      always_ff @(posedge clk) begin
        if (en) begin
          em[s+1] <= ex[s][EXP_FRAC-1-s] ? prod[60:30] : em[s];
          ex[s+1] <= ex[s];
        end
      end
    end
  endgenerate

  logic [60:0] tprod;
  assign tprod = 61'(freq) * 61'(INV_TWO_PI_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      freq <= em[EXP_FRAC] >> ex[EXP_FRAC][25:EXP_FRAC];
      tpp  <= {1'b0, tprod[60:30]};
    end
  end

  assign out_tag = tag[NSTG-1];
  assign out_val = val[NSTG-1];
  assign out_t   = tpp;
endmodule

[rtl/spe_trig.sv]
// Phase multiply, pipelined CORDIC rotation and the saturating add;
// flagged words pass unchanged. Depends on spe_pkg.
`timescale 1ns / 1ps
module spe_trig #(
  parameter int VALUE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  spe_pkg::tag_t         in_tag,
  input  logic [VALUE_BITS-1:0] in_val,
  input  logic [31:0]           in_t,
  output spe_pkg::tag_t         out_tag,
  output logic [VALUE_BITS-1:0] out_val
);
  import spe_pkg::*;

  localparam int SW = VALUE_BITS + 14;

  tag_t                  tag  [0:CORDIC_STEPS];
  logic [VALUE_BITS-1:0] val  [0:CORDIC_STEPS];
  logic [1:0]            quad [0:CORDIC_STEPS];
  logic signed [33:0]    cx   [0:CORDIC_STEPS];
  logic signed [33:0]    cy   [0:CORDIC_STEPS];
  logic signed [33:0]    cz   [0:CORDIC_STEPS];

  logic [43:0] pprod;
  assign pprod = 44'(in_tag.pos) * 44'(in_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0] <= '0;
    end else if (en) begin
      tag[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val[0]  <= in_val;
      quad[0] <= pprod[31:30];
      cx[0]   <= 34'(GAIN_Q30);
      cy[0]   <= '0;
      cz[0]   <= {4'd0, pprod[29:0]};
    end
  end

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] at;
      assign dx = cy[i] >>> i;
      assign dy = cx[i] >>> i;
      assign at = $signed({2'b00, atan_turn(i)});
      always_ff @(posedge clk) begin
        if (rst) begin
          tag[i+1] <= '0;
        end else if (en) begin
          tag[i+1] <= tag[i];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          val[i+1]  <= val[i];
          quad[i+1] <= quad[i];
          if (!cz[i][33]) begin
            cx[i+1] <= cx[i] - dx;
            cy[i+1] <= cy[i] + dy;
            cz[i+1] <= cz[i] - at;
          end else begin
            cx[i+1] <= cx[i] + dx;
            cy[i+1] <= cy[i] - dy;
            cz[i+1] <= cz[i] + at;
          end
        end
      end
    end
  endgenerate

  logic signed [33:0] fx, fy, trig, rnd;
  logic [15:0]            term;
  logic signed [SW-1:0]   sum;
  logic [VALUE_BITS-1:0]  res;
  tag_t                   ftag;
  logic [VALUE_BITS-1:0]  fval;

  localparam logic signed [SW-1:0] VMAX = SW'((2 ** (VALUE_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

  assign fx   = cx[CORDIC_STEPS];
  assign fy   = cy[CORDIC_STEPS];
  assign fval = val[CORDIC_STEPS];
  assign ftag = tag[CORDIC_STEPS];

  always_comb begin
    case ({ftag.want_cos, quad[CORDIC_STEPS]})
      3'b100:  trig = fx;
      3'b101:  trig = -fy;
      3'b110:  trig = -fx;
      3'b111:  trig = fy;
      3'b000:  trig = fy;
      3'b001:  trig = fx;
      3'b010:  trig = -fy;
      default: trig = -fx;
    endcase
    rnd  = trig + 34'sd131072;
    term = rnd[33:18];
    sum  = $signed({{(SW-VALUE_BITS){fval[VALUE_BITS-1]}}, fval})
         + $signed({{(SW-16){term[15]}}, term});
    if (ftag.status != ST_OK) begin
      res = fval;
    end else if (sum > VMAX) begin
      res = VMAX[VALUE_BITS-1:0];
    end else if (sum < VMIN) begin
      res = VMIN[VALUE_BITS-1:0];
    end else begin
      res = sum[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (en) begin
      out_tag <= ftag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val <= res;
    end
  end
endmodule

[rtl/sinusoidal_position_encoding_add.sv]
// Top level of the sinusoidal position encoding adder: config, checks,
// pipeline and output skid. Depends on spe_pkg, spe_freq and spe_trig.
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | position, feature_index, embedding_value
//  out     | out_valid/out_ready| encoded_value, status
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// One word per cycle while the pipeline advances; a word passes through the
// 26-step divider, 12 table products and the CORDIC on its way to out_valid.
// The pipeline advances as a whole while the two-entry output skid has room.
// Reset clears the valid bits and the skid; registers go to 4096 and 512.
`timescale 1ns / 1ps
module sinusoidal_position_encoding_add #(
  parameter int VALUE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           position,
  input  logic [9:0]            feature_index,
  input  logic [VALUE_BITS-1:0] embedding_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] encoded_value,
  output logic [1:0]            status,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [12:0]           cfg_data
);
  import spe_pkg::*;

  logic [12:0] max_positions;
  logic [10:0] model_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_positions <= 13'd4096;
      model_width   <= 11'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_POSITIONS: max_positions <= cfg_data;
        CFG_MODEL_WIDTH:   model_width   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  logic [12:0] plim;
  logic [10:0] wid;
  tag_t        in_tag;
  logic        en;

  assign plim = (max_positions > MAX_POSITIONS) ? MAX_POSITIONS : max_positions;
  assign wid  = (model_width > MAX_WIDTH) ? MAX_WIDTH : model_width;

  always_comb begin
    in_tag.valid    = in_valid;
    in_tag.pos      = position;
    in_tag.want_cos = feature_index[0];
    if ({1'b0, position} >= plim) begin
      in_tag.status = ST_POS;
    end else if ({1'b0, feature_index} >= wid) begin
      in_tag.status = ST_IDX;
    end else begin
      in_tag.status = ST_OK;
    end
  end

  tag_t                  f_tag, t_tag;
  logic [VALUE_BITS-1:0] f_val, t_val;
  logic [31:0]           f_t;

  spe_freq #(.VALUE_BITS(VALUE_BITS)) u_freq (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_tag  (in_tag),
    .in_val  (embedding_value),
    .in_idx  (feature_index),
    .width   (wid),
    .out_tag (f_tag),
    .out_val (f_val),
    .out_t   (f_t)
  );

  spe_trig #(.VALUE_BITS(VALUE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_trig (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_tag  (f_tag),
    .in_val  (f_val),
    .in_t    (f_t),
    .out_tag (t_tag),
    .out_val (t_val)
  );

  logic [1:0]            cnt;
  logic [VALUE_BITS-1:0] val0, val1;
  status_t               st0, st1;
  logic                  push, pop;

  assign en        = (cnt != 2'd2) || out_ready;
  assign in_ready  = en;
  assign push      = en && t_tag.valid;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign encoded_value = val0;
  assign status    = st0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (cnt == 2'd1)) begin
        val0 <= t_val;
        st0  <= t_tag.status;
      end else begin
        val0 <= val1;
        st0  <= st1;
      end
    end else if (push && (cnt == 2'd0)) begin
      val0 <= t_val;
      st0  <= t_tag.status;
    end
    if (push && ((cnt == 2'd2) || ((cnt == 2'd1) && !pop))) begin
      val1 <= t_val;
      st1  <= t_tag.status;
    end
  end
endmodule

[rtl/spe_check.sv]
// Port-level checks for the sinusoidal position encoding adder, bound to the top.
// Depends on sinusoidal_position_encoding_add.
`timescale 1ns / 1ps
module spe_check (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == 2'd0 || status == 2'd1 || status == 2'd2))
    else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("word dropped");
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("stalled while empty");
endmodule

bind sinusoidal_position_encoding_add spe_check u_spe_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status)
);
